// ----- rtl/wsc_pkg.sv -----
// Package for the windowed statistics counters: sizes, codes and beat types.
// Used by every module of the block; depends on nothing.
package wsc_pkg;

  localparam int NUM_COUNTERS = 16;
  localparam int NUM_HIST     = 2;
  localparam int RING_SLOTS   = 4;

  localparam int CNT_W     = 4;
  localparam int HIST_W    = 1;
  localparam int SLOT_W    = $clog2(RING_SLOTS);
  localparam int ENTRIES   = RING_SLOTS * NUM_COUNTERS;
  localparam int HADDR_W   = SLOT_W + CNT_W;
  localparam int NH_W      = 2;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 2;

  localparam logic [63:0] SENTINEL = {8{8'hFE}};

  localparam logic [2:0] ACT_ADD    = 3'd0;
  localparam logic [2:0] ACT_MAX    = 3'd1;
  localparam logic [2:0] ACT_MIN    = 3'd2;
  localparam logic [2:0] ACT_ROTATE = 3'd3;
  localparam logic [2:0] ACT_READ   = 3'd4;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [1:0] STAT_UNINIT    = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_TRIP_ENABLE   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HISTORY_COUNT = 1'd1;

  typedef struct packed {
    logic [2:0]        action;
    logic [CNT_W-1:0]  counter_index;
    logic [63:0]       sample_value;
    logic [HIST_W-1:0] history_index;
  } in_t;

  typedef struct packed {
    logic [63:0] read_value;
    logic [1:0]  status;
  } out_t;

  typedef enum logic {
    FSM_IDLE,
    FSM_EXEC
  } fsm_t;

endpackage

// ----- rtl/wsc_update.sv -----
// Update unit for one counter copy: add, max or min, with sentinel takeover.
// Depends on wsc_pkg for the action codes and the sentinel pattern.
module wsc_update import wsc_pkg::*; (
  input  logic [2:0]  op,
  input  logic        old_vld,
  input  logic [63:0] old_data,
  input  logic [63:0] sample,
  output logic [63:0] new_data
);

  logic [63:0] old_val;

  always_comb begin
    old_val = old_vld ? old_data : SENTINEL;
    if (old_val == SENTINEL) begin
      new_data = sample;
    end else begin
      case (op)
        ACT_ADD: new_data = old_val + sample;
        ACT_MAX: new_data = (old_val > sample) ? old_val : sample;
        default: new_data = (old_val < sample) ? old_val : sample;
      endcase
    end
  end

endmodule

// ----- rtl/windowed_statistics_counters.sv -----
// Top level of the windowed statistics counters: command port, memories and sequencer.
// Depends on wsc_pkg and wsc_update.
//
// Every command is handled as a read and then a write-back: the cycle of acceptance reads the counter memories
// and the following cycle (busy high) modifies and writes them back, so no new command
// is accepted while busy is high. Exactly one result beat follows each command, in
// the cycle right after busy, as busy drops; the receiver cannot stall it. A rotate
// clears the new window through its per-entry valid bits, and no clearing pass follows reset.
module windowed_statistics_counters import wsc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  in_t                  in_data,
  output logic                 out_valid,
  output out_t                 out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  fsm_t state_r, state_nxt;
  in_t  item_r;
  logic accept;

  logic            trip_enable_r;
  logic [NH_W-1:0] history_count_r;
  logic [NH_W-1:0] rings_used;

  logic [63:0]             odo_mem [NUM_COUNTERS];
  logic [63:0]             trip_mem [NUM_COUNTERS];
  logic [NUM_COUNTERS-1:0] odo_vld_r, odo_vld_nxt;
  logic [NUM_COUNTERS-1:0] trip_vld_r, trip_vld_nxt;
  logic [63:0]             odo_rd_r, trip_rd_r;
  logic                    odo_rdv_r, trip_rdv_r;
  logic [63:0]             odo_new, trip_new;

  logic [63:0]         hist_mem [NUM_HIST][ENTRIES];
  logic [ENTRIES-1:0]  hist_vld_r [NUM_HIST];
  logic [ENTRIES-1:0]  hist_vld_nxt [NUM_HIST];
  logic [SLOT_W-1:0]   cur_slot_r [NUM_HIST];
  logic [SLOT_W-1:0]   cur_slot_nxt [NUM_HIST];
  logic [HADDR_W-1:0]  hist_addr [NUM_HIST];
  logic [HADDR_W-1:0]  hist_addr_r [NUM_HIST];
  logic [63:0]         hist_rd_r [NUM_HIST];
  logic                hist_rdv_r [NUM_HIST];
  logic [63:0]         hist_new [NUM_HIST];
  logic [NUM_HIST-1:0] hist_we;

  logic is_upd, in_range, ring_ok, odo_we, trip_we;
  logic out_valid_nxt;
  out_t out_nxt;
  logic [63:0] rd_val;

  logic out_valid_r;
  out_t out_data_r;

  assign accept     = start && !busy;
  assign busy       = (state_r == FSM_EXEC);
  assign rings_used = (history_count_r > NH_W'(NUM_HIST)) ? NH_W'(NUM_HIST) : history_count_r;
  assign in_range   = (32'(item_r.counter_index) < NUM_COUNTERS);
  assign is_upd     = in_range && ((item_r.action == ACT_ADD) || (item_r.action == ACT_MAX)
                      || (item_r.action == ACT_MIN));
  assign ring_ok    = (NH_W'(item_r.history_index) < rings_used);
  assign odo_we     = busy && is_upd;
  assign trip_we    = busy && is_upd && trip_enable_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      FSM_IDLE: if (start) state_nxt = FSM_EXEC;
      FSM_EXEC: state_nxt = FSM_IDLE;
      default:  state_nxt = FSM_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= FSM_IDLE;
      trip_enable_r   <= 1'b1;
      history_count_r <= NH_W'(2);
      out_valid_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_TRIP_ENABLE:   trip_enable_r   <= cfg_wdata[0];
          CFG_HISTORY_COUNT: history_count_r <= cfg_wdata[NH_W-1:0];
          default: ;
        endcase
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_data;
    end
    out_data_r <= out_nxt;
  end

  // Odometer and trip copies.
  always_ff @(posedge clk) begin
    if (accept) begin
      odo_rd_r   <= odo_mem[in_data.counter_index];
      trip_rd_r  <= trip_mem[in_data.counter_index];
      odo_rdv_r  <= odo_vld_r[in_data.counter_index];
      trip_rdv_r <= trip_vld_r[in_data.counter_index];
    end
    if (odo_we) begin
      odo_mem[item_r.counter_index] <= odo_new;
    end
    if (trip_we) begin
      trip_mem[item_r.counter_index] <= trip_new;
    end
  end

  always_comb begin
    odo_vld_nxt  = odo_vld_r;
    trip_vld_nxt = trip_vld_r;
    if (odo_we) odo_vld_nxt[item_r.counter_index] = 1'b1;
    if (trip_we) trip_vld_nxt[item_r.counter_index] = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      odo_vld_r  <= '0;
      trip_vld_r <= '0;
    end else begin
      odo_vld_r  <= odo_vld_nxt;
      trip_vld_r <= trip_vld_nxt;
    end
  end

  wsc_update u_odo (
    .op       (item_r.action),
    .old_vld  (odo_rdv_r),
    .old_data (odo_rd_r),
    .sample   (item_r.sample_value),
    .new_data (odo_new)
  );

  wsc_update u_trip (
    .op       (item_r.action),
    .old_vld  (trip_rdv_r),
    .old_data (trip_rd_r),
    .sample   (item_r.sample_value),
    .new_data (trip_new)
  );

  // History rings, one memory bank per ring.
  for (genvar h = 0; h < NUM_HIST; h++) begin : g_ring
    logic [SLOT_W-1:0] rd_slot;

    assign rd_slot = (in_data.action == ACT_READ) ? SLOT_W'(cur_slot_r[h] - 1'b1)
                                                  : cur_slot_r[h];
    assign hist_addr[h] = {rd_slot, in_data.counter_index};
    assign hist_we[h]   = busy && is_upd && (NH_W'(h) < rings_used);

    wsc_update u_hist (
      .op       (item_r.action),
      .old_vld  (hist_rdv_r[h]),
      .old_data (hist_rd_r[h]),
      .sample   (item_r.sample_value),
      .new_data (hist_new[h])
    );

    always_ff @(posedge clk) begin
      if (accept) begin
        hist_rd_r[h]   <= hist_mem[h][hist_addr[h]];
        hist_rdv_r[h]  <= hist_vld_r[h][hist_addr[h]];
        hist_addr_r[h] <= hist_addr[h];
      end
      if (hist_we[h]) begin
        hist_mem[h][hist_addr_r[h]] <= hist_new[h];
      end
    end

    always_comb begin
      hist_vld_nxt[h] = hist_vld_r[h];
      cur_slot_nxt[h] = cur_slot_r[h];
      if (hist_we[h]) begin
        hist_vld_nxt[h][hist_addr_r[h]] = 1'b1;
      end
      if (busy && (item_r.action == ACT_ROTATE) && ring_ok
          && (HIST_W'(h) == item_r.history_index)) begin
        cur_slot_nxt[h] = SLOT_W'(cur_slot_r[h] + 1'b1);
        hist_vld_nxt[h][{cur_slot_nxt[h], CNT_W'(0)} +: NUM_COUNTERS] = '0;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        hist_vld_r[h] <= '0;
        cur_slot_r[h] <= '0;
      end else begin
        hist_vld_r[h] <= hist_vld_nxt[h];
        cur_slot_r[h] <= cur_slot_nxt[h];
      end
    end
  end

  // Result beat.
  always_comb begin
    out_valid_nxt     = busy;
    out_nxt.read_value = '0;
    out_nxt.status     = STAT_OK;
    rd_val = SENTINEL;
    if (in_range && hist_rdv_r[item_r.history_index]) begin
      rd_val = hist_rd_r[item_r.history_index];
    end
    case (item_r.action)
      ACT_ROTATE: begin
        if (!ring_ok) out_nxt.status = STAT_NOT_FOUND;
      end
      ACT_READ: begin
        if (!ring_ok) begin
          out_nxt.status = STAT_NOT_FOUND;
        end else begin
          out_nxt.read_value = rd_val;
          out_nxt.status     = (rd_val == SENTINEL) ? STAT_UNINIT : STAT_OK;
        end
      end
      default: ;
    endcase
  end

endmodule

// ----- tb/wsc_checker.sv -----
`timescale 1ns / 100ps
// Checker for the windowed statistics counters: watches the command, result and
// configuration ports, predicts every result beat and compares it field by field.
// Depends on wsc_pkg.
module wsc_checker import wsc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 busy,
  input  in_t                  in_data,
  input  logic                 out_valid,
  input  out_t                 out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  output int                   fail_count,
  output int                   pending
);

  logic [63:0] odometer_copy [NUM_COUNTERS];
  logic [63:0] trip_copy [NUM_COUNTERS];
  logic [63:0] window_copy [NUM_HIST][RING_SLOTS][NUM_COUNTERS];
  int unsigned window_slot [NUM_HIST];
  logic        trip_on;
  logic [1:0]  ring_count;
  out_t        expected_beats [$];
  int          fail_total = 0;

  task automatic clear_counters();
    for (int c = 0; c < NUM_COUNTERS; c++) begin
      odometer_copy[c] = SENTINEL;
      trip_copy[c] = SENTINEL;
    end
    for (int h = 0; h < NUM_HIST; h++) begin
      for (int s = 0; s < RING_SLOTS; s++) begin
        for (int c = 0; c < NUM_COUNTERS; c++) window_copy[h][s][c] = SENTINEL;
      end
      window_slot[h] = 0;
    end
    trip_on = 1'b1;
    ring_count = 2'd2;
  endtask

  function automatic logic [63:0] merge_sample(logic [63:0] old, logic [2:0] act,
                                               logic [63:0] v);
    if (old == SENTINEL) return v;
    case (act)
      ACT_ADD: return old + v;
      ACT_MAX: return (old > v) ? old : v;
      default: return (old < v) ? old : v;
    endcase
  endfunction

  task automatic count_command(input in_t cmd, output out_t res);
    int unsigned rings;
    int unsigned ring;
    int unsigned slot;
    rings = (ring_count > NUM_HIST) ? NUM_HIST : ring_count;
    ring = cmd.history_index;
    res.read_value = '0;
    res.status = STAT_OK;
    case (cmd.action)
      ACT_ADD, ACT_MAX, ACT_MIN: begin
        odometer_copy[cmd.counter_index] =
          merge_sample(odometer_copy[cmd.counter_index], cmd.action, cmd.sample_value);
        if (trip_on) begin
          trip_copy[cmd.counter_index] =
            merge_sample(trip_copy[cmd.counter_index], cmd.action, cmd.sample_value);
        end
        for (int h = 0; h < rings; h++) begin
          window_copy[h][window_slot[h]][cmd.counter_index] =
            merge_sample(window_copy[h][window_slot[h]][cmd.counter_index], cmd.action,
                         cmd.sample_value);
        end
      end
      ACT_ROTATE: begin
        if (ring < rings) begin
          window_slot[ring] = (window_slot[ring] + 1) % RING_SLOTS;
          for (int c = 0; c < NUM_COUNTERS; c++) begin
            window_copy[ring][window_slot[ring]][c] = SENTINEL;
          end
        end else begin
          res.status = STAT_NOT_FOUND;
        end
      end
      ACT_READ: begin
        if (ring < rings) begin
          slot = (window_slot[ring] + RING_SLOTS - 1) % RING_SLOTS;
          res.read_value = window_copy[ring][slot][cmd.counter_index];
          if (res.read_value == SENTINEL) res.status = STAT_UNINIT;
        end else begin
          res.status = STAT_NOT_FOUND;
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin : watch
    out_t want;
    out_t got;
    if (!rst_n) begin
      clear_counters();
      expected_beats.delete();
    end else begin
      if (out_valid) begin
        got = out_data;
        if (expected_beats.size() == 0) begin
          $error("result beat with none expected: read_value %h, status %0d",
                 got.read_value, got.status);
          fail_total++;
        end else begin
          want = expected_beats.pop_front();
          if (got.read_value !== want.read_value) begin
            $error("read_value: expected %h, actual %h", want.read_value, got.read_value);
            fail_total++;
          end
          if (got.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            fail_total++;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_TRIP_ENABLE:   trip_on = cfg_wdata[0];
          CFG_HISTORY_COUNT: ring_count = cfg_wdata[1:0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        count_command(in_data, want);
        expected_beats.push_back(want);
      end
    end
    fail_count <= fail_total;
    pending <= expected_beats.size();
  end

endmodule

// ----- tb/tb_windowed_statistics_counters.sv -----
`timescale 1ns / 100ps
// Top of the windowed statistics counters testbench: clock, reset, directed and random
// command beats and configuration writes; the verdict comes from wsc_checker.
// Depends on wsc_pkg, wsc_checker and windowed_statistics_counters.
module tb_windowed_statistics_counters;
  import wsc_pkg::*;

  localparam logic [2:0] ACT_SPARE_FIRST = 3'd5;
  localparam logic [2:0] ACT_SPARE_LAST  = 3'd7;
  localparam int PHASE_BEATS = 310;
  localparam logic       TRIP_SET [5] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
  localparam logic [1:0] RING_SET [5] = '{2'd2, 2'd1, 2'd0, 2'd3, 2'd2};

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  in_t                  in_data = '0;
  logic                 out_valid;
  out_t                 out_data;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_TRIP_ENABLE;
  logic [CFG_W-1:0]     cfg_wdata = '0;
  int                   fail_count;
  int                   pending;

  always #10 clk = ~clk;

  windowed_statistics_counters dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  wsc_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  function automatic in_t command(logic [2:0] act, int idx, logic [63:0] v, int ring);
    in_t c;
    c.action = act;
    c.counter_index = idx[CNT_W-1:0];
    c.sample_value = v;
    c.history_index = ring[HIST_W-1:0];
    return c;
  endfunction

  function automatic logic [63:0] random_sample();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return SENTINEL;
      3, 4, 5: return 64'($urandom_range(0, 1000));
      6: return {32'hFFFF_FFFF, $urandom};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic in_t random_command();
    int pick;
    logic [2:0] act;
    pick = $urandom_range(0, 99);
    if (pick < 60) act = 3'($urandom_range(ACT_ADD, ACT_MIN));
    else if (pick < 70) act = ACT_ROTATE;
    else if (pick < 93) act = ACT_READ;
    else act = 3'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST));
    return command(act, $urandom_range(0, NUM_COUNTERS - 1), random_sample(),
                   $urandom_range(0, NUM_HIST - 1));
  endfunction

  // Leaves start high; the caller either sends the next beat or lowers it.
  task automatic send(input in_t c);
    start <= 1'b1;
    in_data <= c;
    do @(posedge clk); while (busy);
  endtask

  task automatic idle_cycles(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    idle_cycles(1);
    while (pending != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic set_config(input logic trip, input logic [1:0] rings);
    cfg_we <= 1'b1;
    cfg_index <= CFG_TRIP_ENABLE;
    cfg_wdata <= {1'b0, trip};
    @(posedge clk);
    cfg_index <= CFG_HISTORY_COUNT;
    cfg_wdata <= rings;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    #3_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    bit steady;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    set_config(1'b1, 2'd2);

    send(command(ACT_READ, 0, '0, 0));
    send(command(ACT_ADD, 0, 64'd5, 0));
    send(command(ACT_ADD, 0, '1, 0));
    send(command(ACT_MAX, 1, '0, 1));
    send(command(ACT_MAX, 1, '1, 0));
    send(command(ACT_MIN, 2, '1, 1));
    send(command(ACT_MIN, 2, '0, 0));
    send(command(ACT_ADD, 15, SENTINEL, 1));
    send(command(ACT_ROTATE, 0, '0, 0));
    send(command(ACT_READ, 0, '0, 0));
    send(command(ACT_READ, 3, '0, 0));
    send(command(ACT_READ, 15, '1, 0));
    send(command(ACT_READ, 2, '0, 1));
    send(command(3'd5, 4, '1, 1));
    send(command(3'd6, 8, '0, 0));
    send(command(ACT_SPARE_LAST, 15, '1, 1));
    send(command(ACT_ROTATE, 0, '0, 1));
    send(command(ACT_READ, 1, '0, 1));
    drain();
    set_config(1'b0, 2'd1);
    send(command(ACT_ADD, 5, 64'd7, 0));
    send(command(ACT_ROTATE, 0, '0, 1));
    send(command(ACT_READ, 5, '0, 1));
    drain();
    set_config(1'b1, 2'd0);
    send(command(ACT_ADD, 6, 64'd9, 0));
    send(command(ACT_READ, 6, '0, 0));
    send(command(ACT_ROTATE, 6, '0, 0));
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      set_config(TRIP_SET[ph], RING_SET[ph]);
      for (int n = 0; n < PHASE_BEATS; n++) begin
        steady = (ph == 4) && (n < 200);
        send(random_command());
        if (!steady && $urandom_range(0, 99) < 11) idle_cycles($urandom_range(1, 3));
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
